/* rtl/utf8lc_pkg.sv */
// Package for the UTF-8 line and column tracker.
// Holds the transaction payload types, the tracking state type and shared constants.
// Depends on nothing; every other file of the block imports it.
package utf8lc_pkg;

    // Width of the row and column counters and their saturation value.
    localparam int unsigned POS_WIDTH = 24;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    // Depth of the result queue; a power of two.
    localparam int unsigned RES_DEPTH = 4;

    // Byte that ends a row.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Input transaction: one byte of text.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } t_in_item;

    // Output transaction: one position result.
    typedef struct packed {
        logic [POS_WIDTH-1:0] row;
        logic [POS_WIDTH-1:0] column;
        logic                 bad_encoding;
        logic                 end_position;
        logic                 run_end;
    } t_res_item;

    // Tracking state carried from byte to byte.
    typedef struct packed {
        logic [1:0]           pend;
        logic [POS_WIDTH-1:0] line;
        logic [POS_WIDTH-1:0] col;
        logic                 err;
    } t_trk_state;

    // Increment that stops at the top value.
    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? v : v + POS_WIDTH'(1);
    endfunction

endpackage

/* rtl/utf8_line_column_tracker_unit.sv */
// UTF-8 line and column tracker. Takes one text byte per cycle when not stalled and
// reports the zero-based row and column of the character each byte belongs to, with a
// sticky bad-encoding flag; the last byte of a text adds an end-position result and
// clears the state. A result passes through the input register and then the
// four-entry result queue before it is offered. One byte per cycle is sustained while
// final bytes are spread out; the input register holds its byte whenever the result
// queue has fewer than two free entries. Output stall can cause this, and so can final
// bytes close together, since each gives two results and only one result leaves per
// cycle.
// Depends on utf8lc_pkg, utf8lc_step and utf8lc_res_fifo.
module utf8_line_column_tracker_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  utf8lc_pkg::t_in_item  i_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output utf8lc_pkg::t_res_item o_res
);
    import utf8lc_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in;
    t_trk_state r_st;
    logic       n_in_valid;
    t_trk_state st_next;
    t_res_item  res0;
    t_res_item  res1;
    logic       two;
    logic       space2;
    logic       move;
    logic       accept;

    // The held byte moves on once the queue can take both possible results.
    assign move       = r_in_valid && space2;
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept ? 1'b1 : (move ? 1'b0 : r_in_valid);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    // Tracking state advances as each byte leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (move) begin
            r_st <= st_next;
        end
    end

    utf8lc_step u_step (
        .i_item  (r_in),
        .i_state (r_st),
        .o_state (st_next),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two)
    );

    utf8lc_res_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (move),
        .i_push_two (two),
        .i_d0       (res0),
        .i_d1       (res1),
        .i_pop      (!i_out_stall),
        .o_valid    (o_out_valid),
        .o_space2   (space2),
        .o_q        (o_res)
    );

endmodule

/* rtl/utf8lc_step.sv */
// Combinational update of the tracker for one byte.
// Produces the next tracking state and the one or two results of the byte.
// Depends on utf8lc_pkg.
module utf8lc_step (
    input  utf8lc_pkg::t_in_item   i_item,
    input  utf8lc_pkg::t_trk_state i_state,
    output utf8lc_pkg::t_trk_state o_state,
    output utf8lc_pkg::t_res_item  o_res0,
    output utf8lc_pkg::t_res_item  o_res1,
    output logic                   o_two
);
    import utf8lc_pkg::*;

    logic [1:0]           pend;
    logic [POS_WIDTH-1:0] line;
    logic [POS_WIDTH-1:0] col;
    logic                 err;
    logic                 lead;
    logic [POS_WIDTH-1:0] pos_row;
    logic [POS_WIDTH-1:0] pos_col;
    logic [7:0]           b;

    assign b = i_item.text_byte;

    // Decode the byte against the open sequence and update the counters.
    always_comb begin
        pend    = i_state.pend;
        line    = i_state.line;
        col     = i_state.col;
        err     = i_state.err;
        lead    = 1'b1;
        pos_row = line;
        pos_col = col;

        // A continuation is due: either take it, or close the cut-off character.
        if (pend != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                pend = pend - 2'd1;
                if (pend == 2'd0) begin
                    col = sat_inc(col);
                end
                lead = 1'b0;
            end else begin
                err  = 1'b1;
                pend = 2'd0;
                col  = sat_inc(col);
            end
        end

        // The byte starts a new character.
        if (lead) begin
            pos_row = line;
            pos_col = col;
            if (!b[7]) begin
                if (b == NEWLINE_BYTE) begin
                    line = sat_inc(line);
                    col  = '0;
                end else begin
                    col = sat_inc(col);
                end
            end else if (b[7:5] == 3'b110) begin
                pend = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                pend = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                pend = 2'd3;
            end else begin
                err = 1'b1;
                col = sat_inc(col);
            end
        end

        // At the end of the text a still open sequence counts as one bad character.
        if (i_item.final_byte && (pend != 2'd0)) begin
            err  = 1'b1;
            pend = 2'd0;
            col  = sat_inc(col);
        end
    end

    // Results of the byte, and the end position when the text closes.
    always_comb begin
        o_res0.row          = pos_row;
        o_res0.column       = pos_col;
        o_res0.bad_encoding = err;
        o_res0.end_position = 1'b0;
        o_res0.run_end      = !i_item.final_byte;

        o_res1.row          = line;
        o_res1.column       = col;
        o_res1.bad_encoding = err;
        o_res1.end_position = 1'b1;
        o_res1.run_end      = 1'b1;

        o_two = i_item.final_byte;

        if (i_item.final_byte) begin
            o_state = '0;
        end else begin
            o_state.pend = pend;
            o_state.line = line;
            o_state.col  = col;
            o_state.err  = err;
        end
    end

endmodule

/* rtl/utf8lc_res_fifo.sv */
// Small result queue that takes one or two results per cycle and gives one.
// Parts the tracker from the output; input waits only while under two entries are free.
// Depends on utf8lc_pkg.
module utf8lc_res_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_push_two,
    input  utf8lc_pkg::t_res_item i_d0,
    input  utf8lc_pkg::t_res_item i_d1,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_space2,
    output utf8lc_pkg::t_res_item o_q
);
    import utf8lc_pkg::*;

    localparam int unsigned PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);

    t_res_item        r_mem [RES_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] push_n;
    logic             pop_ok;

    assign o_valid  = (r_cnt != '0);
    assign o_space2 = (r_cnt <= CNT_W'(RES_DEPTH - 2));
    assign o_q      = r_mem[r_rd];
    assign pop_ok   = i_pop && o_valid;

    // Pointer and fill count bookkeeping.
    always_comb begin
        push_n = i_push ? (i_push_two ? CNT_W'(2) : CNT_W'(1)) : '0;
        n_wr   = r_wr + PTR_W'(push_n);
        n_rd   = pop_ok ? r_rd + PTR_W'(1) : r_rd;
        n_cnt  = r_cnt + push_n - (pop_ok ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage; the second result lands in the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_d0;
            if (i_push_two) begin
                r_mem[r_wr + PTR_W'(1)] <= i_d1;
            end
        end
    end

endmodule

/* rtl/utf8lc_checker.sv */
// Port-level checks for the UTF-8 line and column tracker.
// Watches the top level's ports only and is attached to it by the bind at the end.
// Depends on utf8lc_pkg and utf8_line_column_tracker_unit.
module utf8lc_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input utf8lc_pkg::t_res_item o_res
);
    import utf8lc_pkg::*;

    // No result is offered straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    // A stalled transaction holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_res))
        else $error("stalled result changed");

    // The end-position result always closes its byte's run.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_res.end_position || o_res.run_end))
        else $error("end position without run end");

    // A result that leaves its run open is followed at once by the end position.
    a_end_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_res.run_end
        |=> o_out_valid && o_res.end_position)
        else $error("end position missing after final byte");

    // The text after an end position starts at row zero, column zero.
    a_new_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_res.end_position) ##1 o_out_valid
        |-> (o_res.row == '0) && (o_res.column == '0))
        else $error("new text does not start at the origin");

endmodule

bind utf8_line_column_tracker_unit utf8lc_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_res       (o_res)
);
